// ===== hw/rtl/trle_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// TGA RLE pixel decoder package
// Shared codes, register indexes and the structs passed between modules.
// ============================================================================
package trle_pkg;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_MODE   = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RLE_ENABLE   = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 4'd3;

    // Pixel formats.
    localparam logic [1:0] MODE_PALETTE = 2'd0;
    localparam logic [1:0] MODE_BGR     = 2'd1;

    // Input item opcodes.
    localparam logic OP_DATA    = 1'b0;
    localparam logic OP_PALETTE = 1'b1;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    typedef struct packed {
        logic [1:0]  pixel_mode;
        logic        rle_enable;
        logic [31:0] pixel_total;
    } trle_cfg_t;

    typedef struct packed {
        logic        wr_en;
        logic        rd_en;
        logic [7:0]  index;
        logic [23:0] color;
    } pal_req_t;

    typedef struct packed {
        logic        palette_pix;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [7:0]  color_index;
        logic [7:0]  repeat_count;
        logic        image_done;
    } pix_res_t;

    // Bytes per pixel for a format; the unused codes decode as BGRA.
    function automatic logic [2:0] bytes_per_pixel(input logic [1:0] mode);
        logic [2:0] n;
        unique case (mode)
            MODE_PALETTE: n = 3'd1;
            MODE_BGR:     n = 3'd3;
            default:      n = 3'd4;
        endcase
        return n;
    endfunction

endpackage

// ===== hw/rtl/trle_cfg_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Configuration write channel
// Register index and write data with a valid/ready handshake.
// ============================================================================
interface trle_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [trle_pkg::CFG_INDEX_W-1:0] index;
    logic [trle_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/trle_in_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Input item channel
// One image data byte or one palette entry write per transfer.
// ============================================================================
interface trle_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] data_byte;
    logic [7:0] palette_index;
    logic [7:0] palette_red;
    logic [7:0] palette_green;
    logic [7:0] palette_blue;

    modport source (output valid, output opcode, output data_byte, output palette_index,
                    output palette_red, output palette_green, output palette_blue,
                    input ready);
    modport sink   (input valid, input opcode, input data_byte, input palette_index,
                    input palette_red, input palette_green, input palette_blue,
                    output ready);
endinterface

// ===== hw/rtl/trle_out_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Pixel result channel
// One decoded RGBA pixel with repeat count and end-of-image flag per transfer.
// ============================================================================
interface trle_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] color_index;
    logic [7:0] repeat_count;
    logic       image_done;

    modport source (output valid, output red, output green, output blue, output alpha,
                    output color_index, output repeat_count, output image_done,
                    input ready);
    modport sink   (input valid, input red, input green, input blue, input alpha,
                    input color_index, input repeat_count, input image_done,
                    output ready);
endinterface

// ===== hw/rtl/trle_cfg_regs.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Configuration registers
// Holds format, RLE enable and image size, and keeps the pixel total width * height.
// ============================================================================
module trle_cfg_regs
(
    input  logic                clk,
    input  logic                rst_n,
    trle_cfg_if.sink            cfg,
    output trle_pkg::trle_cfg_t cfg_state
);

    logic [1:0]  mode_reg,  mode_next;
    logic        rle_reg,   rle_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic [31:0] total_reg, total_next;
    logic [15:0] mul_a;
    logic [15:0] mul_b;

    assign cfg.ready = 1'b1;

    // The total is updated on the same edge as the size register, so it is
    // always consistent with width and height.
    always_comb
    begin
        mode_next   = mode_reg;
        rle_next    = rle_reg;
        width_next  = width_reg;
        height_next = height_reg;
        mul_a       = width_reg;
        mul_b       = height_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                trle_pkg::CFG_PIXEL_MODE:   mode_next = cfg.data[1:0];
                trle_pkg::CFG_RLE_ENABLE:   rle_next  = cfg.data[0];
                trle_pkg::CFG_IMAGE_WIDTH:
                begin
                    width_next = cfg.data;
                    mul_a      = cfg.data;
                end
                trle_pkg::CFG_IMAGE_HEIGHT:
                begin
                    height_next = cfg.data;
                    mul_b       = cfg.data;
                end
                default: ;
            endcase
        end
        total_next = 32'(mul_a) * 32'(mul_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= trle_pkg::MODE_BGR;
            rle_reg    <= 1'b0;
            width_reg  <= '0;
            height_reg <= '0;
            total_reg  <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            rle_reg    <= rle_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            total_reg  <= total_next;
        end
    end

    assign cfg_state.pixel_mode  = mode_reg;
    assign cfg_state.rle_enable  = rle_reg;
    assign cfg_state.pixel_total = total_reg;

endmodule

// ===== hw/rtl/trle_palette.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Palette memory
// Synchronous RAM with registered read and per-entry valid bits for reset.
// ============================================================================
module trle_palette
#(
    parameter int PALETTE_ENTRIES = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  trle_pkg::pal_req_t req,
    output logic [23:0]        rd_color
);

    localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

    logic [23:0]                mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] vld_reg;
    logic [23:0]                rd_reg;
    logic                       hit_reg;
    logic                       in_range;
    logic [AW-1:0]              addr;

    assign in_range = ({1'b0, req.index} < 9'(PALETTE_ENTRIES));
    assign addr     = req.index[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (req.wr_en && in_range)
        begin
            mem[addr] <= req.color;
        end
        else if (req.rd_en)
        begin
            rd_reg <= mem[addr];
        end
    end

    // Entries never written since reset read as black.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            hit_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en && in_range)
            begin
                vld_reg[addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                hit_reg <= in_range && vld_reg[addr];
            end
        end
    end

    assign rd_color = hit_reg ? rd_reg : 24'd0;

endmodule

// ===== hw/rtl/trle_parser.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Stream parser
// Tracks packet headers, pixel bytes and the pixels left in the image.
// ============================================================================
module trle_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic                opcode,
    input  logic [7:0]          data_byte,
    input  logic [7:0]          palette_index,
    input  logic [23:0]         palette_color,
    input  trle_pkg::trle_cfg_t cfg_state,
    output trle_pkg::pal_req_t  pal_req,
    output logic                res_valid,
    output trle_pkg::pix_res_t  res
);

    logic [31:0] pl_reg,  pl_next;
    logic        eh_reg,  eh_next;
    logic        rp_reg,  rp_next;
    logic [7:0]  ppl_reg, ppl_next;
    logic [1:0]  bip_reg, bip_next;
    logic [23:0] pb_reg,  pb_next;

    logic        start;
    logic [31:0] pl_e;
    logic        eh_e;
    logic        rp_e;
    logic [7:0]  ppl_e;
    logic [1:0]  bip_e;
    logic [23:0] pb_e;
    logic [2:0]  need;
    logic [7:0]  cnt_raw;
    logic [7:0]  cnt;
    logic [7:0]  ppl_dec;
    logic [31:0] pl_new;

    // A data byte with no pixels left starts a new image from cleared state.
    assign start = (pl_reg == 32'd0);
    assign pl_e  = start ? cfg_state.pixel_total : pl_reg;
    assign eh_e  = start ? 1'b1  : eh_reg;
    assign rp_e  = start ? 1'b0  : rp_reg;
    assign ppl_e = start ? 8'd0  : ppl_reg;
    assign bip_e = start ? 2'd0  : bip_reg;
    assign pb_e  = start ? 24'd0 : pb_reg;
    assign need  = trle_pkg::bytes_per_pixel(cfg_state.pixel_mode);

    always_comb
    begin
        pl_next   = pl_reg;
        eh_next   = eh_reg;
        rp_next   = rp_reg;
        ppl_next  = ppl_reg;
        bip_next  = bip_reg;
        pb_next   = pb_reg;
        res_valid = 1'b0;
        res       = '0;
        cnt_raw   = 8'd1;
        cnt       = 8'd1;
        ppl_dec   = 8'd0;
        pl_new    = pl_e;

        pal_req.wr_en = 1'b0;
        pal_req.rd_en = 1'b0;
        pal_req.index = data_byte;
        pal_req.color = palette_color;

        if (fire && (opcode == trle_pkg::OP_PALETTE))
        begin
            pal_req.wr_en = 1'b1;
            pal_req.index = palette_index;
        end
        else if (fire)
        begin
            pl_next  = pl_e;
            eh_next  = eh_e;
            rp_next  = rp_e;
            ppl_next = ppl_e;
            bip_next = bip_e;
            pb_next  = pb_e;
            priority if (pl_e == 32'd0)
            begin
                // Empty image: the byte is dropped.
            end
            else if (cfg_state.rle_enable && eh_e)
            begin
                rp_next  = data_byte[7];
                ppl_next = {1'b0, data_byte[6:0]} + 8'd1;
                eh_next  = 1'b0;
                bip_next = 2'd0;
                pb_next  = 24'd0;
            end
            else if (({1'b0, bip_e} + 3'd1) < need)
            begin
                pb_next  = pb_e | (24'(data_byte) << {bip_e, 3'b000});
                bip_next = bip_e + 2'd1;
            end
            else
            begin
                res_valid = 1'b1;
                unique case (need)
                    3'd1:
                    begin
                        res.palette_pix = 1'b1;
                        res.color_index = data_byte;
                        res.alpha       = trle_pkg::ALPHA_OPAQUE;
                        pal_req.rd_en   = 1'b1;
                    end
                    3'd3:
                    begin
                        res.blue  = pb_e[7:0];
                        res.green = pb_e[15:8];
                        res.red   = data_byte;
                        res.alpha = trle_pkg::ALPHA_OPAQUE;
                    end
                    default:
                    begin
                        res.blue  = pb_e[7:0];
                        res.green = pb_e[15:8];
                        res.red   = pb_e[23:16];
                        res.alpha = data_byte;
                    end
                endcase
                bip_next = 2'd0;
                pb_next  = 24'd0;

                if (cfg_state.rle_enable && rp_e)
                begin
                    cnt_raw  = (ppl_e == 8'd0) ? 8'd1 : ppl_e;
                    cnt      = (pl_e < 32'(cnt_raw)) ? pl_e[7:0] : cnt_raw;
                    ppl_next = 8'd0;
                    eh_next  = 1'b1;
                end
                else if (cfg_state.rle_enable)
                begin
                    ppl_dec  = (ppl_e == 8'd0) ? 8'd0 : ppl_e - 8'd1;
                    ppl_next = ppl_dec;
                    if (ppl_dec == 8'd0)
                    begin
                        eh_next = 1'b1;
                    end
                end

                pl_new           = pl_e - 32'(cnt);
                pl_next          = pl_new;
                res.repeat_count = cnt;
                res.image_done   = (pl_new == 32'd0);
                if (pl_new == 32'd0)
                begin
                    eh_next  = 1'b1;
                    rp_next  = 1'b0;
                    ppl_next = 8'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pl_reg  <= '0;
            eh_reg  <= 1'b1;
            rp_reg  <= 1'b0;
            ppl_reg <= '0;
            bip_reg <= '0;
            pb_reg  <= '0;
        end
        else
        begin
            pl_reg  <= pl_next;
            eh_reg  <= eh_next;
            rp_reg  <= rp_next;
            ppl_reg <= ppl_next;
            bip_reg <= bip_next;
            pb_reg  <= pb_next;
        end
    end

endmodule

// ===== hw/rtl/trle_pixel_out.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Pixel output stage
// Aligns results with the palette read and holds them in an output register.
// ============================================================================
module trle_pixel_out
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               res_valid,
    input  trle_pkg::pix_res_t res,
    input  logic [23:0]        pal_color,
    output logic               accept_ready,
    trle_out_if.source         pixels
);

    logic               s1_valid_reg, s1_valid_next;
    trle_pkg::pix_res_t s1_reg;
    logic               out_valid_reg, out_valid_next;
    trle_pkg::pix_res_t out_reg, out_next;
    logic               s1_adv;

    // The aligned stage moves on whenever the output register is free or
    // being emptied by a transfer in this cycle.
    assign s1_adv       = !out_valid_reg || pixels.ready;
    assign accept_ready = !s1_valid_reg || s1_adv;

    always_comb
    begin
        s1_valid_next  = accept_ready ? res_valid : s1_valid_reg;
        out_valid_next = s1_adv ? s1_valid_reg : out_valid_reg;
        out_next       = out_reg;
        if (s1_adv)
        begin
            out_next = s1_reg;
            // Palette pixels take their color from the read issued with the last byte.
            if (s1_reg.palette_pix)
            begin
                out_next.red   = pal_color[23:16];
                out_next.green = pal_color[15:8];
                out_next.blue  = pal_color[7:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_ready)
        begin
            s1_reg <= res;
        end
        out_reg <= out_next;
    end

    assign pixels.valid        = out_valid_reg;
    assign pixels.red          = out_reg.red;
    assign pixels.green        = out_reg.green;
    assign pixels.blue         = out_reg.blue;
    assign pixels.alpha        = out_reg.alpha;
    assign pixels.color_index  = out_reg.color_index;
    assign pixels.repeat_count = out_reg.repeat_count;
    assign pixels.image_done   = out_reg.image_done;

endmodule

// ===== hw/rtl/tga_rle_pixel_decoder_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// TGA RLE pixel decoder
// Decodes a TGA image-data byte stream into RGBA pixels with repeat counts.
// ============================================================================
// The stream channel carries one item per transfer: an image data byte, or a
// palette entry write. The pixels channel returns one decoded pixel per
// transfer; header bytes, partial pixel bytes and palette items give none.
// A run packet gives one pixel with its repeat count, clipped to the pixels
// left, and image_done marks the last pixel of the image.
// The cfg channel is always ready and writes pixel mode, RLE enable, width
// and height; write it only while the block is idle.
// Throughput is one item per clock while the output is not stalled, set by
// the packet state being updated once per item and the single palette RAM
// port. A pixel reaches the output through the aligned stage, registered
// together with the palette read, and then through the output register.
// Reset clears packet state, the pixel counter and the palette valid bits,
// so every palette entry reads black until written; no clearing pass runs.
// When the receiver stalls, the output register and the aligned stage hold
// their pixels, and stream.ready drops once both are full.
// ============================================================================
module tga_rle_pixel_decoder_top
#(
    parameter int PALETTE_ENTRIES = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    trle_cfg_if.sink   cfg,
    trle_in_if.sink    stream,
    trle_out_if.source pixels
);

    trle_pkg::trle_cfg_t cfg_state;
    trle_pkg::pal_req_t  pal_req;
    trle_pkg::pix_res_t  res;
    logic                res_valid;
    logic [23:0]         pal_color;
    logic                accept_ready;
    logic                fire;

    assign stream.ready = accept_ready;
    assign fire         = stream.valid && accept_ready;

    trle_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cfg_state (cfg_state)
    );

    trle_parser u_parser
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .opcode        (stream.opcode),
        .data_byte     (stream.data_byte),
        .palette_index (stream.palette_index),
        .palette_color ({stream.palette_red, stream.palette_green, stream.palette_blue}),
        .cfg_state     (cfg_state),
        .pal_req       (pal_req),
        .res_valid     (res_valid),
        .res           (res)
    );

    trle_palette
    #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    )
    u_palette
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (pal_req),
        .rd_color (pal_color)
    );

    trle_pixel_out u_out
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .res_valid    (res_valid),
        .res          (res),
        .pal_color    (pal_color),
        .accept_ready (accept_ready),
        .pixels       (pixels)
    );

endmodule
